[rtl/core/vfv_pkg.sv]
`default_nettype none
// ----------------------------------------------------------------------------
// vfv_pkg
// Shared types and constants for the voxel face visibility block.
// ----------------------------------------------------------------------------
package vfv_pkg;

	localparam int GRID    = 16;
	localparam int ROWS    = GRID * GRID;
	localparam int DEPTH   = 2 * GRID + 1;
	localparam int PERIOD  = ROWS + GRID + 1;
	localparam int CNT_W   = $clog2(PERIOD);
	localparam int POS_W   = $clog2(GRID);
	localparam int FIELD_W = 16;
	localparam int IDX_W   = 8;
	localparam int IN_W    = FIELD_W;
	localparam int OUT_W   = 7 * FIELD_W + IDX_W;

	typedef logic [GRID-1:0]    row_t;
	typedef logic [FIELD_W-1:0] field_t;

	// neighbour rows for the voxel row under test, already gated at the grid edge
	typedef struct packed {
		logic             valid;
		row_t             self_row;
		row_t             xn_row;
		row_t             xp_row;
		row_t             yn_row;
		row_t             yp_row;
		logic [IDX_W-1:0] index;
	} window_t;

	typedef struct packed {
		logic [IDX_W-1:0] row_index;
		field_t           occluded_row;
		field_t           face_ypos;
		field_t           face_yneg;
		field_t           face_xpos;
		field_t           face_xneg;
		field_t           face_zpos;
		field_t           face_zneg;
	} result_t;

endpackage
`default_nettype wire

[rtl/core/voxel_face_visibility.sv]
`default_nettype none
// ----------------------------------------------------------------------------
// voxel_face_visibility
// Streams voxel rows and reports visible faces and occlusion per voxel.
// ----------------------------------------------------------------------------
// throughput: one row transfer per cycle while the result output is not stalled
// the result for grid row c is computed at input transfer c+GRID+1, one plane plus
//   one row behind, and is presented from the output register
// the first GRID+1 transfers of each frame give no result; GRID+1 padding rows close it
// reset: clears frame counters and output valid; the row delay line is not reset
module voxel_face_visibility
	import vfv_pkg::*;
(
	input  wire logic             clk,
	input  wire logic             arst_n,
	input  wire logic             s_axis_tvalid,
	output logic                  s_axis_tready,
	input  wire logic [IN_W-1:0]  s_axis_tdata,   // solid_row
	output logic                  m_axis_tvalid,
	input  wire logic             m_axis_tready,
	output logic [OUT_W-1:0]      m_axis_tdata    // face_zneg, face_zpos, face_xneg,
	                                              // face_xpos, face_yneg, face_ypos,
	                                              // occluded_row, row_index
);

	logic    take;
	window_t win;
	result_t cull_res;
	result_t out_res;

	assign take = s_axis_tvalid && s_axis_tready;

	vfv_window u_window (
		.clk       (clk),
		.arst_n    (arst_n),
		.take      (take),
		.solid_row (s_axis_tdata),
		.win       (win)
	);

	vfv_cull u_cull (
		.win (win),
		.res (cull_res)
	);

	vfv_out u_out (
		.clk       (clk),
		.arst_n    (arst_n),
		.push      (take && win.valid),
		.push_res  (cull_res),
		.pop_ready (m_axis_tready),
		.out_valid (m_axis_tvalid),
		.out_res   (out_res),
		.in_ready  (s_axis_tready)
	);

	assign m_axis_tdata = out_res;

endmodule
`default_nettype wire

[rtl/core/vfv_window.sv]
`default_nettype none
// ----------------------------------------------------------------------------
// vfv_window
// Row delay line and frame position counters; presents the stencil taps.
// ----------------------------------------------------------------------------
module vfv_window
	import vfv_pkg::*;
(
	input  wire logic           clk,
	input  wire logic           arst_n,
	input  wire logic           take,
	input  wire logic [IN_W-1:0] solid_row,
	output window_t             win
);

	row_t             delay_q [DEPTH];
	logic [CNT_W-1:0] count_q;
	logic [POS_W-1:0] plane_q;
	logic [POS_W-1:0] row_q;
	logic [IDX_W-1:0] index_q;
	logic             active;
	logic             frame_end;

	assign active    = (count_q >= CNT_W'(GRID + 1));
	assign frame_end = (count_q == CNT_W'(PERIOD - 1));

	always_ff @(posedge clk) begin
		if (take) begin
			delay_q[0] <= (count_q < CNT_W'(ROWS)) ? GRID'(solid_row) : '0;
			for (int i = 1; i < DEPTH; i++) begin
				delay_q[i] <= delay_q[i-1];
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			count_q <= '0;
			plane_q <= '0;
			row_q   <= '0;
			index_q <= '0;
		end else if (take) begin
			if (frame_end) begin
				count_q <= '0;
				plane_q <= '0;
				row_q   <= '0;
				index_q <= '0;
			end else begin
				count_q <= count_q + 1'b1;
				if (active) begin
					index_q <= index_q + 1'b1;
					if (row_q == POS_W'(GRID - 1)) begin
						row_q   <= '0;
						plane_q <= plane_q + 1'b1;
					end else begin
						row_q <= row_q + 1'b1;
					end
				end
			end
		end
	end

	always_comb begin
		win.valid    = active;
		win.self_row = delay_q[GRID];
		win.xn_row   = (plane_q != '0) ? delay_q[2*GRID] : '0;
		win.xp_row   = (plane_q != POS_W'(GRID - 1)) ? delay_q[0] : '0;
		win.yn_row   = (row_q != '0) ? delay_q[GRID+1] : '0;
		win.yp_row   = (row_q != POS_W'(GRID - 1)) ? delay_q[GRID-1] : '0;
		win.index    = index_q;
	end

endmodule
`default_nettype wire

[rtl/core/vfv_cull.sv]
`default_nettype none
// ----------------------------------------------------------------------------
// vfv_cull
// Face visibility and occlusion for one voxel row from its stencil taps.
// ----------------------------------------------------------------------------
module vfv_cull
	import vfv_pkg::*;
(
	input  wire window_t win,
	output result_t      res
);

	row_t s;
	row_t f_zn, f_zp, f_xn, f_xp, f_yn, f_yp;
	row_t any_vis;

	// a face is hidden only where both voxels are solid
	always_comb begin
		s       = win.self_row;
		f_zn    = ~(s & (s << 1));
		f_zp    = ~(s & (s >> 1));
		f_xn    = ~(s & win.xn_row);
		f_xp    = ~(s & win.xp_row);
		f_yn    = ~(s & win.yn_row);
		f_yp    = ~(s & win.yp_row);
		any_vis = f_zn | f_zp | f_xn | f_xp | f_yn | f_yp;

		res.face_zneg    = FIELD_W'(f_zn);
		res.face_zpos    = FIELD_W'(f_zp);
		res.face_xneg    = FIELD_W'(f_xn);
		res.face_xpos    = FIELD_W'(f_xp);
		res.face_yneg    = FIELD_W'(f_yn);
		res.face_ypos    = FIELD_W'(f_yp);
		res.occluded_row = FIELD_W'(s & ~any_vis);
		res.row_index    = win.index;
	end

endmodule
`default_nettype wire

[rtl/core/vfv_out.sv]
`default_nettype none
// ----------------------------------------------------------------------------
// vfv_out
// Result register with a skid stage so one more input is taken under a stall.
// ----------------------------------------------------------------------------
module vfv_out
	import vfv_pkg::*;
(
	input  wire logic    clk,
	input  wire logic    arst_n,
	input  wire logic    push,
	input  wire result_t push_res,
	input  wire logic    pop_ready,
	output logic         out_valid,
	output result_t      out_res,
	output logic         in_ready
);

	result_t out_q;
	result_t skid_q;
	logic    out_valid_q;
	logic    skid_valid_q;
	logic    pop;

	assign pop       = out_valid_q && pop_ready;
	assign out_valid = out_valid_q;
	assign out_res   = out_q;
	assign in_ready  = !skid_valid_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q  <= 1'b0;
			skid_valid_q <= 1'b0;
		end else begin
			if (skid_valid_q) begin
				if (pop) begin
					skid_valid_q <= 1'b0;
				end
			end else if (push) begin
				if (out_valid_q && !pop) begin
					skid_valid_q <= 1'b1;
				end else begin
					out_valid_q <= 1'b1;
				end
			end else if (pop) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (skid_valid_q) begin
			if (pop) begin
				out_q <= skid_q;
			end
		end else if (push) begin
			if (out_valid_q && !pop) begin
				skid_q <= push_res;
			end else begin
				out_q <= push_res;
			end
		end
	end

endmodule
`default_nettype wire

[rtl/core/vfv_checker.sv]
`default_nettype none
// ----------------------------------------------------------------------------
// vfv_checker
// Port-level checks for voxel_face_visibility, bound to the top level.
// ----------------------------------------------------------------------------
module vfv_checker
	import vfv_pkg::*;
(
	input wire logic             clk,
	input wire logic             arst_n,
	input wire logic             s_axis_tready,
	input wire logic             m_axis_tvalid,
	input wire logic             m_axis_tready,
	input wire logic [OUT_W-1:0] m_axis_tdata
);

	logic [FIELD_W-1:0] any_face;
	logic [FIELD_W-1:0] occ;

	assign any_face = m_axis_tdata[FIELD_W-1:0] | m_axis_tdata[2*FIELD_W-1:FIELD_W]
		| m_axis_tdata[3*FIELD_W-1:2*FIELD_W] | m_axis_tdata[4*FIELD_W-1:3*FIELD_W]
		| m_axis_tdata[5*FIELD_W-1:4*FIELD_W] | m_axis_tdata[6*FIELD_W-1:5*FIELD_W];
	assign occ = m_axis_tdata[7*FIELD_W-1:6*FIELD_W];

	// output transfer holds under stall
	a_hold_valid: assert property (@(posedge clk) disable iff (!arst_n)
		m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid)
		else $error("m_axis_tvalid dropped before transfer");

	a_hold_data: assert property (@(posedge clk) disable iff (!arst_n)
		m_axis_tvalid && !m_axis_tready |=> $stable(m_axis_tdata))
		else $error("m_axis_tdata changed under stall");

	// input backs up only behind a stalled result
	a_ready_drop: assert property (@(posedge clk) disable iff (!arst_n)
		!s_axis_tready |-> m_axis_tvalid && $past(m_axis_tvalid && !m_axis_tready))
		else $error("s_axis_tready low without a stalled output");

	// an occluded voxel shows no visible face
	a_occluded: assert property (@(posedge clk) disable iff (!arst_n)
		m_axis_tvalid |-> (occ & any_face) == '0)
		else $error("occluded voxel with a visible face");

	// nothing comes out right after reset
	a_reset_idle: assert property (@(posedge clk)
		!arst_n |=> !m_axis_tvalid && s_axis_tready)
		else $error("output valid after reset");

endmodule

bind voxel_face_visibility vfv_checker u_vfv_checker (.*);
`default_nettype wire
